@@ design/wlmf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlmf_pkg
// Shared types and constants of the 3x3 window LBP / median filter: field
// widths, mode and register codes, reset values, configuration struct.
// ----------------------------------------------------------------------------
package wlmf_pkg;

  // default parameter values
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 16;

  // port field widths
  localparam int IO_PIXEL_W = 16;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;

  // configuration field widths
  localparam int MODE_W = 2;
  localparam int LWID_W = 11;
  localparam int HGT_W  = 13;
  localparam int WGT_W  = 64;

  // width used to compare columns against the line width
  localparam int SIZE_W = 14;

  // window geometry
  localparam int WIN_DIM    = 3;
  localparam int WIN_N      = WIN_DIM * WIN_DIM;
  localparam int CENTRE_IDX = WIN_N / 2;
  localparam int NBR        = WIN_N - 1;
  localparam int MIN_SIZE   = WIN_DIM;
  localparam int HEIGHT_LIMIT = 4096;

  // lbp sum widths: pair sums and the full sum of eight bytes
  localparam int PSUM_W    = 9;
  localparam int LBP_SUM_W = 11;

  // apb port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 2;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_COPY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LBP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_MODE         = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHTS      = 2'd3;

  // reset values
  localparam logic [MODE_W-1:0] RST_MODE         = MODE_LBP;
  localparam logic [LWID_W-1:0] RST_LINE_WIDTH   = 11'd640;
  localparam logic [HGT_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
  localparam logic [WGT_W-1:0]  RST_WEIGHTS      = 64'h8040_2010_0804_0201;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LWID_W-1:0] line_width;
    logic [HGT_W-1:0]  frame_height;
    logic [WGT_W-1:0]  weights;
  } cfg_t;

  // position of the window centre
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

endpackage
`default_nettype wire

@@ design/wlmf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlmf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module wlmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/wlmf_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlmf_regs
// APB configuration registers: mode, line width, frame height and the eight
// neighbour weights. Registers sit at 8-byte spacing on a 64-bit data bus.
// ----------------------------------------------------------------------------
module wlmf_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wlmf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [wlmf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [wlmf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output wlmf_pkg::cfg_t                   cfg
);
  import wlmf_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= RST_MODE;
      cfg.line_width   <= RST_LINE_WIDTH;
      cfg.frame_height <= RST_FRAME_HEIGHT;
      cfg.weights      <= RST_WEIGHTS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:         cfg.mode         <= pwdata[MODE_W-1:0];
        REG_LINE_WIDTH:   cfg.line_width   <= pwdata[LWID_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[HGT_W-1:0];
        REG_WEIGHTS:      cfg.weights      <= pwdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_MODE:         prdata = APB_DATA_W'(cfg.mode);
      REG_LINE_WIDTH:   prdata = APB_DATA_W'(cfg.line_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg.frame_height);
      REG_WEIGHTS:      prdata = APB_DATA_W'(cfg.weights);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/wlmf_window.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlmf_window
// Raster position counters, the line store RAM (upper and middle line packed
// in one word per column) and the 3x3 window registers. Each column is read
// at acceptance and written back one stage later with {middle, new pixel}.
// ----------------------------------------------------------------------------
module wlmf_window #(
  parameter int MAX_WIDTH  = wlmf_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = wlmf_pkg::DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wlmf_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wlmf_pkg::IO_PIXEL_W-1:0] pixel,
  output logic [PIXEL_BITS-1:0]           win [wlmf_pkg::WIN_N],
  output wlmf_pkg::pos_t                  win_pos,
  output logic                            win_valid,
  input  logic                            win_ready
);
  import wlmf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // position of the next input pixel
  logic [CW-1:0]    col_cnt;
  logic [ROW_W-1:0] row_cnt;

  logic [SIZE_W-1:0] width_eff;
  logic [HGT_W-1:0]  height_eff;
  logic [SIZE_W-1:0] col_ext;
  logic [SIZE_W-1:0] col_inc;
  logic [HGT_W-1:0]  row_ext;
  logic [HGT_W-1:0]  row_inc;
  logic              col_wrap;
  logic              row_wrap;
  logic              emit;
  pos_t              pos_in;

  logic accept;
  logic go_1;
  logic rdy_w;

  // read stage
  logic                  v1;
  logic [PIXEL_BITS-1:0] s1_px;
  logic [CW-1:0]         s1_col;
  logic                  s1_emit;
  pos_t                  s1_pos;

  logic [PIXEL_BITS-1:0]   rd_up;
  logic [PIXEL_BITS-1:0]   rd_mid;
  logic [2*PIXEL_BITS-1:0] rd_data;

  // clamp frame size
  always_comb begin
    if (cfg.line_width < LWID_W'(MIN_SIZE)) begin
      width_eff = SIZE_W'(MIN_SIZE);
    end else if (SIZE_W'(cfg.line_width) > SIZE_W'(MAX_WIDTH)) begin
      width_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      width_eff = SIZE_W'(cfg.line_width);
    end
    if (cfg.frame_height < HGT_W'(MIN_SIZE)) begin
      height_eff = HGT_W'(MIN_SIZE);
    end else if (cfg.frame_height > HGT_W'(HEIGHT_LIMIT)) begin
      height_eff = HGT_W'(HEIGHT_LIMIT);
    end else begin
      height_eff = cfg.frame_height;
    end
  end

  // position compare and centre coordinates
  always_comb begin
    col_ext  = SIZE_W'(col_cnt);
    col_inc  = col_ext + SIZE_W'(1);
    row_ext  = HGT_W'(row_cnt);
    row_inc  = row_ext + HGT_W'(1);
    col_wrap = col_inc >= width_eff;
    row_wrap = row_inc >= height_eff;
    emit     = (row_cnt >= ROW_W'(WIN_DIM - 1)) && (col_cnt >= CW'(WIN_DIM - 1)) &&
               (row_ext < height_eff) && (col_ext < width_eff);
    pos_in.row = row_cnt - ROW_W'(1);
    pos_in.col = COL_W'(col_cnt - CW'(1));
  end

  // stage handshake
  assign rdy_w    = !win_valid || win_ready;
  assign go_1     = v1 && rdy_w;
  assign in_stall = v1 && !rdy_w;
  assign accept   = in_valid && !in_stall;

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_cnt <= '0;
        row_cnt <= row_wrap ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= CW'(col_inc);
      end
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept || (v1 && !go_1);
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= pixel[PIXEL_BITS-1:0];
      s1_col  <= col_cnt;
      s1_emit <= emit;
      s1_pos  <= pos_in;
    end
  end

  // line store: word holds {upper, middle}
  wlmf_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (go_1),
    .waddr (s1_col),
    .wdata ({rd_mid, s1_px}),
    .re    (accept),
    .raddr (col_cnt),
    .rdata (rd_data)
  );

  assign rd_up  = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
  assign rd_mid = rd_data[PIXEL_BITS-1:0];

  // window shift by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_N; i++) begin
        win[i] <= '0;
      end
    end else if (go_1) begin
      for (int r = 0; r < WIN_DIM; r++) begin
        win[WIN_DIM*r]     <= win[WIN_DIM*r + 1];
        win[WIN_DIM*r + 1] <= win[WIN_DIM*r + 2];
      end
      win[WIN_DIM - 1]   <= rd_up;
      win[2*WIN_DIM - 1] <= rd_mid;
      win[WIN_N - 1]     <= s1_px;
    end
  end

  // window slot: pending result for the kernel
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (go_1) begin
      win_valid <= s1_emit;
    end else if (win_ready) begin
      win_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go_1) begin
      win_pos <= s1_pos;
    end
  end

  // write-back never hits the column read in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    go_1 && accept |-> s1_col != col_cnt)
    else $error("line store read and write collide on one column");

  // read data holds while the read stage waits
  assert property (@(posedge clk) disable iff (rst)
    v1 && !go_1 |=> $stable(rd_data))
    else $error("line store read data lost during stall");

endmodule
`default_nettype wire

@@ design/wlmf_kernel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlmf_kernel
// Three-stage compute pipeline on a complete window: row sort and lbp compare,
// median-of-three merge and pair sums, then mode select into the output
// register. Each stage holds on downstream stall and collapses bubbles.
// ----------------------------------------------------------------------------
module wlmf_kernel #(
  parameter int PIXEL_BITS = wlmf_pkg::DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wlmf_pkg::cfg_t                  cfg,
  input  logic [PIXEL_BITS-1:0]           win [wlmf_pkg::WIN_N],
  input  wlmf_pkg::pos_t                  win_pos,
  input  logic                            win_valid,
  output logic                            win_ready,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wlmf_pkg::IO_PIXEL_W-1:0] value,
  output logic [wlmf_pkg::ROW_W-1:0]      centre_row,
  output logic [wlmf_pkg::COL_W-1:0]      centre_col
);
  import wlmf_pkg::*;

  function automatic logic [PIXEL_BITS-1:0] min3(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b,
                                                 input logic [PIXEL_BITS-1:0] c);
    logic ab, ac, bc;
    ab = a > b;
    ac = a > c;
    bc = b > c;
    if (!ab && !ac) return a;
    else if (!bc) return b;
    else return c;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] max3(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b,
                                                 input logic [PIXEL_BITS-1:0] c);
    logic ba, ca, cb;
    ba = b > a;
    ca = c > a;
    cb = c > b;
    if (!ba && !ca) return a;
    else if (!cb) return b;
    else return c;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] med3(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b,
                                                 input logic [PIXEL_BITS-1:0] c);
    logic ab, ac, bc;
    ab = a > b;
    ac = a > c;
    bc = b > c;
    if (ab == bc) return b;
    else if (ab != ac) return a;
    else return c;
  endfunction

  // handshake
  logic rdy_o, rdy_p2, rdy_p1;
  logic go_w;
  logic vp1, vp2;

  // stage 1 registers
  logic [PIXEL_BITS-1:0] p1_mn [WIN_DIM];
  logic [PIXEL_BITS-1:0] p1_md [WIN_DIM];
  logic [PIXEL_BITS-1:0] p1_mx [WIN_DIM];
  logic [NBR-1:0]        p1_mask;
  logic [PIXEL_BITS-1:0] p1_centre;
  pos_t                  p1_pos;
  logic [NBR-1:0]        ge_mask;

  // stage 2 registers
  logic [PIXEL_BITS-1:0] p2_lo, p2_mi, p2_hi;
  logic [PSUM_W-1:0]     p2_psum [NBR/2];
  logic [PIXEL_BITS-1:0] p2_centre;
  pos_t                  p2_pos;
  logic [PSUM_W-1:0]     psum [NBR/2];

  logic [LBP_SUM_W-1:0] lbp_sum;
  logic [IO_PIXEL_W-1:0] value_next;

  assign rdy_o     = !out_valid || !out_stall;
  assign rdy_p2    = !vp2 || rdy_o;
  assign rdy_p1    = !vp1 || rdy_p2;
  assign win_ready = rdy_p1;
  assign go_w      = win_valid && win_ready;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vp1       <= 1'b0;
      vp2       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vp1       <= go_w || (vp1 && !rdy_p2);
      vp2       <= (vp1 && rdy_p2) || (vp2 && !rdy_o);
      out_valid <= (vp2 && rdy_o) || (out_valid && out_stall);
    end
  end

  // neighbours at least the centre
  always_comb begin
    for (int k = 0; k < NBR; k++) begin
      ge_mask[k] = (k < CENTRE_IDX) ? (win[k] >= win[CENTRE_IDX])
                                    : (win[k + 1] >= win[CENTRE_IDX]);
    end
  end

  // stage 1: sort each row, lbp compares
  always_ff @(posedge clk) begin
    if (go_w) begin
      for (int r = 0; r < WIN_DIM; r++) begin
        p1_mn[r] <= min3(win[WIN_DIM*r], win[WIN_DIM*r + 1], win[WIN_DIM*r + 2]);
        p1_md[r] <= med3(win[WIN_DIM*r], win[WIN_DIM*r + 1], win[WIN_DIM*r + 2]);
        p1_mx[r] <= max3(win[WIN_DIM*r], win[WIN_DIM*r + 1], win[WIN_DIM*r + 2]);
      end
      p1_mask   <= ge_mask;
      p1_centre <= win[CENTRE_IDX];
      p1_pos    <= win_pos;
    end
  end

  // weighted pair sums
  always_comb begin
    for (int j = 0; j < NBR/2; j++) begin
      psum[j] = (p1_mask[2*j]     ? PSUM_W'(cfg.weights[16*j +: 8])     : '0) +
                (p1_mask[2*j + 1] ? PSUM_W'(cfg.weights[16*j + 8 +: 8]) : '0);
    end
  end

  // stage 2: merge rows, pair sums
  always_ff @(posedge clk) begin
    if (vp1 && rdy_p2) begin
      p2_lo     <= max3(p1_mn[0], p1_mn[1], p1_mn[2]);
      p2_mi     <= med3(p1_md[0], p1_md[1], p1_md[2]);
      p2_hi     <= min3(p1_mx[0], p1_mx[1], p1_mx[2]);
      p2_psum   <= psum;
      p2_centre <= p1_centre;
      p2_pos    <= p1_pos;
    end
  end

  // final sum and mode select
  always_comb begin
    lbp_sum = LBP_SUM_W'(p2_psum[0]) + LBP_SUM_W'(p2_psum[1]) +
              LBP_SUM_W'(p2_psum[2]) + LBP_SUM_W'(p2_psum[3]);
    case (cfg.mode)
      MODE_LBP:    value_next = IO_PIXEL_W'(lbp_sum);
      MODE_MEDIAN: value_next = IO_PIXEL_W'(med3(p2_lo, p2_mi, p2_hi));
      MODE_COPY:   value_next = IO_PIXEL_W'(p2_centre);
      default:     value_next = IO_PIXEL_W'(p2_centre);
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (vp2 && rdy_o) begin
      value      <= value_next;
      centre_row <= p2_pos.row;
      centre_col <= p2_pos.col;
    end
  end

  // a window taken from the window stage lands in stage 1
  assert property (@(posedge clk) disable iff (rst)
    go_w |=> vp1)
    else $error("window transaction dropped before stage 1");

  // a blocked stage 2 keeps its median candidates
  assert property (@(posedge clk) disable iff (rst)
    vp2 && !rdy_o |=> vp2 && $stable(p2_mi) && $stable(p2_pos))
    else $error("stage 2 changed while blocked");

endmodule
`default_nettype wire

@@ design/window_lbp_median_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// window_lbp_median_filter
// 3x3 window filter on a raster pixel stream: local binary pattern, median of
// nine, or centre copy, with APB configuration.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and, once two rows and two
// columns have arrived, gives one result per interior pixel with its centre
// row and column; border pixels give no transaction. The sustained rate is
// one pixel per clock while out_stall is low: the line store is one simple
// dual-port RAM holding the upper and middle line per column, read when a
// pixel is accepted and written back as the read stage moves on. A result
// passes through the read stage, window shift, two compute stages and the
// output register after its pixel is accepted. Each stage holds under
// out_stall and empty stages fill, so the pipeline holds up to five
// transactions and the input stalls only once all of them are full. Line
// store contents are undefined after reset until the first two rows have
// passed. Change the configuration only while no transaction is in flight.
// ----------------------------------------------------------------------------
module window_lbp_median_filter #(
  parameter int MAX_WIDTH  = wlmf_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = wlmf_pkg::DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wlmf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [wlmf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wlmf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  // pixel input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wlmf_pkg::IO_PIXEL_W-1:0] pixel,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wlmf_pkg::IO_PIXEL_W-1:0] value,
  output logic [wlmf_pkg::ROW_W-1:0]      centre_row,
  output logic [wlmf_pkg::COL_W-1:0]      centre_col
);
  import wlmf_pkg::*;

  cfg_t                  cfg;
  logic [PIXEL_BITS-1:0] win [WIN_N];
  pos_t                  win_pos;
  logic                  win_valid;
  logic                  win_ready;

  // configuration registers
  wlmf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // line store and window
  wlmf_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .win       (win),
    .win_pos   (win_pos),
    .win_valid (win_valid),
    .win_ready (win_ready)
  );

  // compute pipeline
  wlmf_kernel #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_kernel (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .win        (win),
    .win_pos    (win_pos),
    .win_valid  (win_valid),
    .win_ready  (win_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .centre_row (centre_row),
    .centre_col (centre_col)
  );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 window LBP / median / copy filter.
// ----------------------------------------------------------------------------
// Streams raster pixels over the valid/stall input and keeps its own line
// stores, 3x3 window and position counters to predict each centre result.
// Results are checked in order, field by field. Configuration goes over the
// APB port only while the block is idle. The run covers every mode and the
// unused mode, size clamping at both ends, mid-frame size changes, a long
// output hold and a sender pause.
// ----------------------------------------------------------------------------
module tb;
  import wlmf_pkg::*;

  localparam int MAXW           = DEF_MAX_WIDTH;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;

  // unused mode code, behaves as copy
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_kind_t;

  typedef struct packed {
    logic [IO_PIXEL_W-1:0] value;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
  } centre_result_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [IO_PIXEL_W-1:0] pixel    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [IO_PIXEL_W-1:0] value;
  logic [ROW_W-1:0]      centre_row;
  logic [COL_W-1:0]      centre_col;

  window_lbp_median_filter i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .centre_row (centre_row),
    .centre_col (centre_col)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stimulus and expectation stores
  logic [IO_PIXEL_W-1:0] pending_pixels [$];
  centre_result_t        expected_results [$];
  int                    error_count    = 0;
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  int                    hold_request   = 0;
  int                    hold_seen      = 0;
  int                    hold_left      = 0;
  int                    idle_cycles    = 0;

  // predictor copy of the filter state
  logic [IO_PIXEL_W-1:0] upper_copy  [MAXW];
  logic [IO_PIXEL_W-1:0] middle_copy [MAXW];
  logic [1:0]            col_writes  [MAXW];
  logic [IO_PIXEL_W-1:0] win_pix [WIN_DIM][WIN_DIM];
  int unsigned           next_col = 0;
  int unsigned           next_row = 0;
  logic [MODE_W-1:0]     cfg_mode    = RST_MODE;
  logic [LWID_W-1:0]     cfg_width   = RST_LINE_WIDTH;
  logic [HGT_W-1:0]      cfg_height  = RST_FRAME_HEIGHT;
  logic [WGT_W-1:0]      cfg_weights = RST_WEIGHTS;

  function automatic int unsigned eff_size(input int unsigned raw, input int unsigned hi);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // advance the window by one pixel and queue the centre result if interior
  function automatic void filter_step(input logic [IO_PIXEL_W-1:0] px);
    int unsigned           w, h, c, r;
    int                    i, j, k;
    logic [IO_PIXEL_W-1:0] up, mid, ctr, tmp;
    logic [IO_PIXEL_W-1:0] s [WIN_N];
    logic [LBP_SUM_W-1:0]  sum;
    centre_result_t        res;
    w = eff_size(cfg_width, MAXW);
    h = eff_size(cfg_height, HEIGHT_LIMIT);
    c = next_col;
    r = next_row;
    up = '0;
    mid = '0;
    if (c < MAXW) begin
      up = upper_copy[c];
      mid = middle_copy[c];
      upper_copy[c] = mid;
      middle_copy[c] = px;
      if (col_writes[c] != 2'd2) col_writes[c] = col_writes[c] + 2'd1;
    end
    for (i = 0; i < WIN_DIM; i++) begin
      win_pix[i][0] = win_pix[i][1];
      win_pix[i][1] = win_pix[i][2];
    end
    win_pix[0][2] = up;
    win_pix[1][2] = mid;
    win_pix[2][2] = px;

    if (r >= 2 && c >= 2 && r < h && c < w) begin
      ctr = win_pix[1][1];
      case (cfg_mode)
        MODE_LBP: begin
          sum = '0;
          k = 0;
          for (i = 0; i < WIN_N; i++) begin
            if (i != CENTRE_IDX) begin
              if (win_pix[i / WIN_DIM][i % WIN_DIM] >= ctr) sum += cfg_weights[8*k +: 8];
              k++;
            end
          end
          res.value = IO_PIXEL_W'(sum);
        end
        MODE_MEDIAN: begin
          for (i = 0; i < WIN_N; i++) s[i] = win_pix[i / WIN_DIM][i % WIN_DIM];
          for (i = 0; i < WIN_N - 1; i++) begin
            for (j = 0; j < WIN_N - 1 - i; j++) begin
              if (s[j] > s[j+1]) begin
                tmp = s[j];
                s[j] = s[j+1];
                s[j+1] = tmp;
              end
            end
          end
          res.value = s[CENTRE_IDX];
        end
        default: res.value = ctr;
      endcase
      res.row = ROW_W'(r - 1);
      res.col = COL_W'(c - 1);
      expected_results.push_back(res);
    end

    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  // widest line whose upper and middle entries all hold written pixels
  function automatic int unsigned filled_width();
    int unsigned c;
    c = 0;
    while (c < MAXW && col_writes[c] == 2'd2) c++;
    return c;
  endfunction

  // pixels still needed to bring the position counters back to the frame start
  function automatic int unsigned steps_to_frame_start();
    int unsigned c, r, w, h, n;
    w = eff_size(cfg_width, MAXW);
    h = eff_size(cfg_height, HEIGHT_LIMIT);
    c = next_col;
    r = next_row;
    n = 0;
    while (c != 0 || r != 0) begin
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c = c + 1;
      end
      n++;
    end
    return n;
  endfunction

  function automatic logic [IO_PIXEL_W-1:0] random_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      // clustered values give ties against the centre
      2, 3: return IO_PIXEL_W'(16'h7FFE + $urandom_range(3));
      4: return IO_PIXEL_W'($urandom_range(3));
      default: return IO_PIXEL_W'($urandom);
    endcase
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) filter_step(pixel);
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          pixel <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin : result_monitor
    centre_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transaction: value %0h row %0d col %0d",
                 value, centre_row, centre_col);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (value !== want.value) begin
            $error("value: expected %0h, actual %0h", want.value, value);
            error_count++;
          end
          if (centre_row !== want.row) begin
            $error("centre_row: expected %0d, actual %0d", want.row, centre_row);
            error_count++;
          end
          if (centre_col !== want.col) begin
            $error("centre_col: expected %0d, actual %0d", want.col, centre_col);
            error_count++;
          end
        end
      end
      // long hold on request, else random stall
      if (hold_seen != hold_request) begin
        hold_seen <= hold_request;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_idle(input idle_kind_t kind);
    case (kind)
      IDLE_SEND: begin send_idle_pct = 57; recv_stall_pct = 0; end
      IDLE_RECV: begin send_idle_pct = 0; recv_stall_pct = 57; end
      IDLE_BOTH: begin send_idle_pct = 9; recv_stall_pct = 9; end
      default:   begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // apb write: setup cycle, then access until pready
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 3'b000});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:         cfg_mode = data[MODE_W-1:0];
      REG_LINE_WIDTH:   cfg_width = data[LWID_W-1:0];
      REG_FRAME_HEIGHT: cfg_height = data[HGT_W-1:0];
      REG_WEIGHTS:      cfg_weights = data[WGT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [LWID_W-1:0] width,
                            input logic [HGT_W-1:0] height, input logic [WGT_W-1:0] weights);
    write_reg(REG_MODE, APB_DATA_W'(mode));
    write_reg(REG_LINE_WIDTH, APB_DATA_W'(width));
    write_reg(REG_FRAME_HEIGHT, APB_DATA_W'(height));
    write_reg(REG_WEIGHTS, APB_DATA_W'(weights));
  endtask

  // wait until every pixel is taken and every result is back, then let the
  // pipeline empty of border pixels; sampled on the falling edge so the
  // driver's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixels(input int unsigned n);
    repeat (n) pending_pixels.push_back(random_pixel());
  endtask

  task automatic to_frame_start();
    push_pixels(steps_to_frame_start());
    wait_idle();
  endtask

  task automatic random_config();
    logic [MODE_W-1:0] mode;
    logic [LWID_W-1:0] width;
    logic [HGT_W-1:0]  height;
    logic [WGT_W-1:0]  weights;
    int unsigned       limit;
    mode = MODE_W'($urandom_range(3));
    case ($urandom_range(9))
      0: width = LWID_W'($urandom_range(2));
      1: width = LWID_W'($urandom_range(40, 11));
      default: width = LWID_W'($urandom_range(10, 3));
    endcase
    case ($urandom_range(9))
      0: height = HGT_W'($urandom_range(2));
      1: height = HGT_W'($urandom_range(8191, 4097));
      default: height = HGT_W'($urandom_range(8, 3));
    endcase
    case ($urandom_range(4))
      0: weights = '0;
      1: weights = '1;
      2: weights = RST_WEIGHTS;
      default: weights = {$urandom, $urandom};
    endcase
    // widening mid-frame may only reach columns with filled line entries
    limit = filled_width();
    if ((next_col != 0 || next_row != 0) && eff_size(width, MAXW) > limit)
      width = LWID_W'(limit);
    set_config(mode, width, height, weights);
  endtask

  task automatic push_list(input logic [IO_PIXEL_W-1:0] px [$]);
    foreach (px[i]) pending_pixels.push_back(px[i]);
  endtask

  initial begin : stimulus
    int i, j, phase;
    for (i = 0; i < MAXW; i++) begin
      upper_copy[i] = '0;
      middle_copy[i] = '0;
      col_writes[i] = '0;
    end
    for (i = 0; i < WIN_DIM; i++)
      for (j = 0; j < WIN_DIM; j++) win_pix[i][j] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: width below minimum, one result per mode with a mode change
    // mid-frame, ties against the centre, extreme pixel values
    set_idle(IDLE_NONE);
    set_config(MODE_LBP, 11'd1, 13'd6, '1);
    push_list('{16'hFFFF, 16'h0000, 16'h8000,
                16'h7FFF, 16'h8000, 16'h8001,
                16'h8000, 16'hFFFF, 16'h0000});
    wait_idle();
    write_reg(REG_MODE, APB_DATA_W'(MODE_MEDIAN));
    push_list('{16'h1234, 16'h0001, 16'h1234});
    wait_idle();
    write_reg(REG_MODE, APB_DATA_W'(MODE_COPY));
    push_list('{16'h5555, 16'hAAAA, 16'h0000});
    wait_idle();
    write_reg(REG_MODE, APB_DATA_W'(MODE_UNUSED));
    push_list('{16'h0000, 16'hFFFF, 16'h7FFF});
    wait_idle();

    // long output hold while pixels keep coming, then a sender pause mid-frame
    to_frame_start();
    set_config(MODE_LBP, 11'd16, 13'd6, RST_WEIGHTS);
    hold_request++;
    push_pixels(56);
    wait_idle();
    push_pixels(40);

    // width above the maximum clamps to the maximum, first row only
    wait_idle();
    set_idle(IDLE_BOTH);
    set_config(MODE_MEDIAN, 11'd2047, 13'd3, {$urandom, $urandom});
    push_pixels(24);

    // height above the limit clamps; narrowing mid-row wraps the column
    wait_idle();
    set_idle(IDLE_RECV);
    set_config(MODE_COPY, 11'd3, 13'd8191, RST_WEIGHTS);
    push_pixels(30);

    // random phases with random sizes, modes and weights
    for (phase = 0; phase < 9; phase++) begin
      wait_idle();
      set_idle(idle_kind_t'(phase % 4));
      random_config();
      push_pixels($urandom_range(70, 30));
    end

    wait_idle();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
